// ===== design/ldpc_bf_pkg.sv =====
`default_nettype none

package ldpc_bf_pkg;

  localparam int DEF_BLOCK_BITS  = 128;
  localparam int DEF_CHECK_COUNT = 64;
  localparam int EDGES_PER_BIT   = 3;
  localparam int GROUP_BITS      = 8;
  localparam int CHECK_W         = 6;
  localparam int ROUND_W         = 9;
  localparam int VOTE_W          = 3;
  localparam int EDGE_W          = EDGES_PER_BIT * CHECK_W;
  localparam int IN_DATA_W       = 24;
  localparam int OUT_DATA_W      = 24;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [7:0]        MAX_ITER_RESET = 8'd20;
  localparam logic [VOTE_W-1:0] VOTE_MID       = VOTE_W'((EDGES_PER_BIT + 1) / 2);

  // register index, taken from paddr[2]
  localparam logic REG_MAX_ITER = 1'b0;

endpackage

`default_nettype wire

// ===== design/ldpc_bit_flip_decoder.sv =====
`default_nettype none

// Channel  Direction  Handshake                  Payload
// in_      slave      in_tvalid / in_tready      bit, three check indices; tlast = last bit
// out_     master     out_tvalid / out_tready    decoded byte, rounds used; tlast = last group
// cfg_     APB slave  psel/penable/pwrite, pready max_iterations at address 0
//
// Loading keeps in_tready high, taking bits back to back. A final transfer starts
// decoding of n stored bits. Each round moves one edge per cycle through the single
// parity and vote unit, after a read state per bit on the bit and edge stores (one
// read port each). Output gathers each group bit by bit and holds it until taken.
// in_tready is low from the final transfer until the last group has left.
// Reset (rst_n, synchronous) returns to loading with max_iterations 20.

module ldpc_bit_flip_decoder
  import ldpc_bf_pkg::*;
#(
  parameter int BLOCK_BITS  = DEF_BLOCK_BITS,
  parameter int CHECK_COUNT = DEF_CHECK_COUNT
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // [0] received_bit, [6:1] first_check, [12:7] second_check, [18:13] third_check
  input  wire  [IN_DATA_W-1:0]   in_tdata,
  // final_bit
  input  wire                    in_tlast,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  // [7:0] decoded_byte, [16:8] rounds_used
  output logic [OUT_DATA_W-1:0]  out_tdata,
  // last_group
  output logic                   out_tlast,
  input  wire                    cfg_psel,
  input  wire                    cfg_penable,
  input  wire                    cfg_pwrite,
  input  wire  [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire  [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  localparam int AW = $clog2(BLOCK_BITS);
  localparam int NW = $clog2(BLOCK_BITS + 1);
  localparam int CW = $clog2(CHECK_COUNT);

  typedef enum logic [3:0] {
    S_LOAD,
    S_ROUND,
    S_P_RD,
    S_P_EDGE,
    S_CHECK,
    S_F_RD,
    S_F_EDGE,
    S_O_RD,
    S_O_CAP,
    S_O_WAIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [7:0]             max_iter_r;
  logic [NW-1:0]          fill_r, fill_nxt;
  logic [NW-1:0]          nbits_r, nbits_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic [1:0]             edge_r, edge_nxt;
  logic [ROUND_W-1:0]     round_r, round_nxt;
  logic [ROUND_W-1:0]     rounds_r, rounds_nxt;
  logic [VOTE_W-1:0]      vote_r, vote_nxt;
  logic [CHECK_COUNT-1:0] par_r, par_nxt;
  logic [7:0]             byte_r, byte_nxt;
  logic                   last_r, last_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic                   bit_mem [BLOCK_BITS];
  logic [EDGE_W-1:0]      edge_mem [BLOCK_BITS];
  logic                   rd_bit_r;
  logic [EDGE_W-1:0]      rd_edges_r;

  logic                   bit_we, bit_wd, edge_we;
  logic [AW-1:0]          bit_wa;
  logic                   in_xfer, stored, last_bit, chk_valid, par_bit, new_bit;
  logic [NW-1:0]          fill_inc;
  logic [CHECK_W-1:0]     chk;
  logic [VOTE_W-1:0]      vote_sum;
  logic                   cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_ITER) ? {24'd0, max_iter_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= MAX_ITER_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_MAX_ITER) begin
      max_iter_r <= cfg_pwdata[7:0];
    end
  end

  assign in_tready  = (state_r == S_LOAD);
  assign in_xfer    = in_tvalid && in_tready;
  assign stored     = (fill_r != NW'(BLOCK_BITS));
  assign fill_inc   = fill_r + NW'(stored);
  assign last_bit   = (NW'(idx_r) + NW'(1)) == nbits_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, rounds_r, byte_r};
  assign out_tlast  = last_r;

  always_comb begin
    case (edge_r)
      2'd0:    chk = rd_edges_r[CHECK_W-1:0];
      2'd1:    chk = rd_edges_r[2*CHECK_W-1:CHECK_W];
      2'd2:    chk = rd_edges_r[3*CHECK_W-1:2*CHECK_W];
      default: chk = '0;
    endcase
  end

  assign chk_valid = {1'b0, chk} < (CHECK_W + 1)'(CHECK_COUNT);
  assign par_bit   = par_r[chk[CW-1:0]];
  assign vote_sum  = ((edge_r == 2'd0) ? VOTE_W'(rd_bit_r) : vote_r)
                   + ((chk_valid) ? VOTE_W'(rd_bit_r ^ par_bit) : '0);
  assign new_bit   = (vote_sum > VOTE_MID) ? 1'b1 :
                     (vote_sum < VOTE_MID) ? 1'b0 : rd_bit_r;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    nbits_nxt     = nbits_r;
    idx_nxt       = idx_r;
    edge_nxt      = edge_r;
    round_nxt     = round_r;
    rounds_nxt    = rounds_r;
    vote_nxt      = vote_r;
    par_nxt       = par_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    bit_we        = 1'b0;
    bit_wa        = fill_r[AW-1:0];
    bit_wd        = in_tdata[0];
    edge_we       = 1'b0;

    case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          bit_we   = stored;
          edge_we  = stored;
          fill_nxt = fill_inc;
          if (in_tlast) begin
            nbits_nxt = fill_inc;
            fill_nxt  = '0;
            idx_nxt   = '0;
            round_nxt = '0;
            state_nxt = S_ROUND;
          end
        end
      end
      S_ROUND: begin
        idx_nxt = '0;
        if (round_r == {1'b0, max_iter_r}) begin
          rounds_nxt = {1'b0, max_iter_r} + ROUND_W'(1);
          state_nxt  = S_O_RD;
        end else begin
          par_nxt   = '0;
          state_nxt = S_P_RD;
        end
      end
      S_P_RD: begin
        edge_nxt  = '0;
        state_nxt = S_P_EDGE;
      end
      S_P_EDGE: begin
        if (chk_valid) begin
          par_nxt[chk[CW-1:0]] = par_bit ^ rd_bit_r;
        end
        edge_nxt = edge_r + 2'd1;
        if (edge_r == 2'd2) begin
          if (last_bit) begin
            state_nxt = S_CHECK;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_P_RD;
          end
        end
      end
      S_CHECK: begin
        idx_nxt = '0;
        if (par_r == '0) begin
          rounds_nxt = round_r + ROUND_W'(1);
          state_nxt  = S_O_RD;
        end else begin
          state_nxt = S_F_RD;
        end
      end
      S_F_RD: begin
        edge_nxt  = '0;
        state_nxt = S_F_EDGE;
      end
      S_F_EDGE: begin
        vote_nxt = vote_sum;
        edge_nxt = edge_r + 2'd1;
        if (edge_r == 2'd2) begin
          bit_we = 1'b1;
          bit_wa = idx_r;
          bit_wd = new_bit;
          if (last_bit) begin
            round_nxt = round_r + ROUND_W'(1);
            state_nxt = S_ROUND;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_F_RD;
          end
        end
      end
      S_O_RD: begin
        state_nxt = S_O_CAP;
      end
      S_O_CAP: begin
        byte_nxt                 = (idx_r[2:0] == 3'd0) ? 8'd0 : byte_r;
        byte_nxt[idx_r[2:0]]     = rd_bit_r;
        if (idx_r[2:0] == 3'd7 || last_bit) begin
          out_valid_nxt = 1'b1;
          last_nxt      = last_bit;
          state_nxt     = S_O_WAIT;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_O_RD;
        end
      end
      S_O_WAIT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (last_r) begin
            state_nxt = S_LOAD;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_O_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      fill_r      <= '0;
      round_r     <= '0;
      par_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      round_r     <= round_nxt;
      par_r       <= par_nxt;
      out_valid_r <= out_valid_nxt;
    end
    nbits_r  <= nbits_nxt;
    idx_r    <= idx_nxt;
    edge_r   <= edge_nxt;
    rounds_r <= rounds_nxt;
    vote_r   <= vote_nxt;
    byte_r   <= byte_nxt;
    last_r   <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (bit_we) begin
      bit_mem[bit_wa] <= bit_wd;
    end
    rd_bit_r <= bit_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[fill_r[AW-1:0]] <= in_tdata[EDGE_W:1];
    end
    rd_edges_r <= edge_mem[idx_r];
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a group is pending");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= NW'(BLOCK_BITS))
    else $error("fill count past block size");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD && state_r != S_ROUND && state_r != S_CHECK) |->
      (NW'(idx_r) < nbits_r))
    else $error("bit index past codeword length");

  a_rounds_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (rounds_r <= {1'b0, max_iter_r} + ROUND_W'(1)) && (rounds_r != '0))
    else $error("round count out of range");

  a_load_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("no return to loading after last group");

endmodule

`default_nettype wire
